>>> rtl/lrtb_pkg.sv
// Shared types, constants, rate tables and the control program for the
// link-rate to encoder-bitrate block. No dependencies.
package lrtb_pkg;

    localparam int BR_W    = 19;
    localparam int ID_W    = 8;
    localparam int ACT_W   = 3;
    localparam int HR_W    = 7;
    localparam int PHY_W   = 12;
    localparam int CIDX_W  = 2;
    localparam int STEP_W  = 3;

    localparam logic [BR_W-1:0]  FLOOR_KBPS     = 19'd500;
    localparam logic [PHY_W-1:0] UNKNOWN_RATE   = 12'd120;
    localparam logic [HR_W-1:0]  HEADROOM_RESET = 7'd20;
    localparam logic [BR_W-1:0]  CAP_RESET      = 19'd25000;
    localparam logic [BR_W-1:0]  START_RESET    = 19'd25000;

    localparam logic [6:0] LEGACY_LAST = 7'h0b;
    localparam logic [6:0] HT_FIRST    = 7'h0c;
    localparam logic [6:0] HT_LAST     = 7'h2b;
    localparam logic [6:0] VHT_FIRST   = 7'h2c;
    localparam logic [6:0] VHT_LAST    = 7'h53;

    // event kinds
    localparam logic [ACT_W-1:0] ACT_DROP      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RISE      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DEGRADED  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RECOVERED = 3'd3;

    // result commands
    localparam logic CMD_ENCODER = 1'b0;
    localparam logic CMD_DRIVER  = 1'b1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_HEADROOM = 2'd0;
    localparam logic [CIDX_W-1:0] REG_CAP      = 2'd1;
    localparam logic [CIDX_W-1:0] REG_SYNC     = 2'd2;
    localparam logic [CIDX_W-1:0] REG_START    = 2'd3;

    // datapath operations
    localparam logic [2:0] OP_ACCEPT = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_CLAMP  = 3'd3;
    localparam logic [2:0] OP_EMIT_A = 3'd4;
    localparam logic [2:0] OP_EMIT_B = 3'd5;

    // step hold conditions
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_IN   = 2'd1;
    localparam logic [1:0] HOLD_OUT  = 2'd2;

    // jump conditions
    localparam logic [2:0] COND_NEXT   = 3'd0;
    localparam logic [2:0] COND_ALWAYS = 3'd1;
    localparam logic [2:0] COND_SKIP   = 3'd2;
    localparam logic [2:0] COND_SAME   = 3'd3;
    localparam logic [2:0] COND_SINGLE = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        hold_on;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic [2:0] op;
        logic       go;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic skip;
        logic same;
        logic single;
    } status_t;

    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            3'd0:    w = '{OP_ACCEPT, HOLD_IN,   COND_SKIP,   3'd0};
            3'd1:    w = '{OP_LOOKUP, HOLD_NONE, COND_NEXT,   3'd0};
            3'd2:    w = '{OP_MUL,    HOLD_NONE, COND_NEXT,   3'd0};
            3'd3:    w = '{OP_CLAMP,  HOLD_NONE, COND_SAME,   3'd0};
            3'd4:    w = '{OP_EMIT_A, HOLD_OUT,  COND_SINGLE, 3'd0};
            3'd5:    w = '{OP_EMIT_B, HOLD_OUT,  COND_ALWAYS, 3'd0};
            default: w = '{OP_ACCEPT, HOLD_NONE, COND_ALWAYS, 3'd0};
        endcase
        return w;
    endfunction

    function automatic logic [9:0] legacy_rate(input logic [3:0] idx);
        logic [9:0] r;
        case (idx)
            4'd0:    r = 10'd10;
            4'd1:    r = 10'd20;
            4'd2:    r = 10'd55;
            4'd3:    r = 10'd110;
            4'd4:    r = 10'd60;
            4'd5:    r = 10'd90;
            4'd6:    r = 10'd120;
            4'd7:    r = 10'd180;
            4'd8:    r = 10'd240;
            4'd9:    r = 10'd360;
            4'd10:   r = 10'd480;
            4'd11:   r = 10'd540;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] mcs_rate(input logic [3:0] mcs, input logic sg);
        logic [9:0] r;
        case (mcs)
            4'd0:    r = sg ? 10'd72  : 10'd65;
            4'd1:    r = sg ? 10'd144 : 10'd130;
            4'd2:    r = sg ? 10'd217 : 10'd195;
            4'd3:    r = sg ? 10'd289 : 10'd260;
            4'd4:    r = sg ? 10'd433 : 10'd390;
            4'd5:    r = sg ? 10'd578 : 10'd520;
            4'd6:    r = sg ? 10'd650 : 10'd585;
            4'd7:    r = sg ? 10'd722 : 10'd650;
            4'd8:    r = sg ? 10'd867 : 10'd780;
            4'd9:    r = sg ? 10'd963 : 10'd867;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

    // PHY rate in 100 kbps units
    function automatic logic [PHY_W-1:0] phy_rate(input logic [ID_W-1:0] id);
        logic [6:0]       base;
        logic [6:0]       d;
        logic [1:0]       n;
        logic [3:0]       mcs;
        logic [PHY_W-1:0] r;
        base = id[6:0];
        d    = 7'd0;
        n    = 2'd0;
        mcs  = 4'd0;
        if (base <= LEGACY_LAST) begin
            r = PHY_W'(legacy_rate(base[3:0]));
        end
        else if (base <= HT_LAST) begin
            d   = base - HT_FIRST;
            mcs = {1'b0, d[2:0]};
            n   = d[4:3];
            r   = PHY_W'(mcs_rate(mcs, id[7])) * PHY_W'({1'b0, n} + 3'd1);
        end
        else if (base <= VHT_LAST) begin
            // split into stream count and MCS by compares against 10, 20, 30
            d = base - VHT_FIRST;
            if (d >= 7'd30)
                n = 2'd3;
            else if (d >= 7'd20)
                n = 2'd2;
            else if (d >= 7'd10)
                n = 2'd1;
            else
                n = 2'd0;
            mcs = 4'(d - 7'(n) * 7'd10);
            r   = PHY_W'(mcs_rate(mcs, id[7])) * PHY_W'({1'b0, n} + 3'd1);
        end
        else begin
            r = UNKNOWN_RATE;
        end
        return r;
    endfunction

endpackage

>>> rtl/lrtb_in_if.sv
// Input channel of rate-change events: valid, ready and event fields.
// Depends on lrtb_pkg.
interface lrtb_in_if
    import lrtb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  old_rate_id;
    logic [ID_W-1:0]  new_rate_id;

    modport source (output valid, output action, output old_rate_id, output new_rate_id,
                    input ready);
    modport sink   (input valid, input action, input old_rate_id, input new_rate_id,
                    output ready);
endinterface

>>> rtl/lrtb_out_if.sv
// Output channel of encoder and driver commands: valid, ready and command fields.
// Depends on lrtb_pkg.
interface lrtb_out_if
    import lrtb_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            command;
    logic [BR_W-1:0] enc_kbps;
    logic [ID_W-1:0] rate_id;
    logic            final_res;

    modport source (output valid, output command, output enc_kbps, output rate_id,
                    output final_res, input ready);
    modport sink   (input valid, input command, input enc_kbps, input rate_id,
                    input final_res, output ready);
endinterface

>>> rtl/link_rate_to_encoder_bitrate.sv
// Link-rate to encoder-bitrate controller, one event at a time under a six-step program.
// Each accepted event passes the lookup, multiply and clamp steps; the first command is
// registered at an emit step, and in sync mode a second one follows. An ignored kind
// or an unchanged bitrate returns to the accept step; emit steps wait for a free output.
// Reset: asynchronous rst_n restores register defaults, bitrate 25000 kbps, step zero.
// Depends on lrtb_pkg, lrtb_in_if, lrtb_out_if, lrtb_sequencer and lrtb_datapath.
module link_rate_to_encoder_bitrate
    import lrtb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [BR_W-1:0]   cfg_data,
    lrtb_in_if.sink           in_ch,
    lrtb_out_if.source        out_ch
);
    ctrl_t   ctrl;
    status_t status;

    lrtb_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    lrtb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .status    (status),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );
endmodule

>>> rtl/lrtb_sequencer.sv
// Step counter and control-word fetch with hold and conditional jumps.
// Depends on lrtb_pkg (program, control and status types).
module lrtb_sequencer
    import lrtb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              go;
    logic              taken;

    always_comb
    begin
        word = ucode(step_reg);
        case (word.hold_on)
            HOLD_IN:  go = status.in_valid;
            HOLD_OUT: go = status.out_free;
            default:  go = 1'b1;
        endcase
        case (word.cond)
            COND_ALWAYS: taken = 1'b1;
            COND_SKIP:   taken = status.skip;
            COND_SAME:   taken = status.same;
            COND_SINGLE: taken = status.single;
            default:     taken = 1'b0;
        endcase
        if (!go)
            step_next = step_reg;
        else if (taken)
            step_next = word.target;
        else
            step_next = step_reg + 3'd1;
        ctrl.op = word.op;
        ctrl.go = go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end
endmodule

>>> rtl/lrtb_datapath.sv
// Config registers, rate lookup, headroom multiply, cap/floor, bitrate state
// and the output register. Depends on lrtb_pkg and both channel interfaces.
module lrtb_datapath
    import lrtb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [BR_W-1:0]   cfg_data,
    input  ctrl_t             ctrl,
    output status_t           status,
    lrtb_in_if.sink           in_ch,
    lrtb_out_if.source        out_ch
);
    logic [HR_W-1:0]  headroom_reg;
    logic [BR_W-1:0]  cap_reg;
    logic             sync_reg;
    logic [BR_W-1:0]  current_reg;

    logic [ID_W-1:0]  new_id_reg;
    logic             drop_reg;
    logic [PHY_W-1:0] phy_reg;
    logic [BR_W-1:0]  prod_reg;
    logic [BR_W-1:0]  br_reg;

    logic             out_valid_reg;
    logic             out_cmd_reg;
    logic [BR_W-1:0]  out_br_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic             out_fin_reg;

    logic [BR_W-1:0]  clamped;
    logic             emit;
    logic             emit_cmd;
    logic             emit_fin;

    always_comb
    begin
        clamped = prod_reg;
        if (cap_reg != '0 && clamped > cap_reg)
            clamped = cap_reg;
        if (clamped < FLOOR_KBPS)
            clamped = FLOOR_KBPS;
    end

    assign status.in_valid = in_ch.valid;
    assign status.out_free = !out_valid_reg || out_ch.ready;
    assign status.skip     = in_ch.action > ACT_RECOVERED;
    assign status.same     = clamped == current_reg;
    assign status.single   = !sync_reg;

    assign in_ch.ready = ctrl.op == OP_ACCEPT;

    // first transfer: encoder unless a sync-mode rise; second is the other one
    always_comb
    begin
        emit     = ctrl.go && (ctrl.op == OP_EMIT_A || ctrl.op == OP_EMIT_B);
        emit_cmd = CMD_ENCODER;
        emit_fin = 1'b1;
        if (ctrl.op == OP_EMIT_A) begin
            emit_cmd = (sync_reg && !drop_reg) ? CMD_DRIVER : CMD_ENCODER;
            emit_fin = !sync_reg;
        end
        else begin
            emit_cmd = drop_reg ? CMD_DRIVER : CMD_ENCODER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            headroom_reg  <= HEADROOM_RESET;
            cap_reg       <= CAP_RESET;
            sync_reg      <= 1'b0;
            current_reg   <= START_RESET;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_HEADROOM: headroom_reg <= cfg_data[HR_W-1:0];
                    REG_CAP:      cap_reg      <= cfg_data;
                    REG_SYNC:     sync_reg     <= cfg_data[0];
                    REG_START:    current_reg  <= cfg_data;
                    default:      ;
                endcase
            end
            if (ctrl.go && ctrl.op == OP_CLAMP && !status.same)
                current_reg <= clamped;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.go) begin
            case (ctrl.op)
                OP_ACCEPT:
                begin
                    new_id_reg <= in_ch.new_rate_id;
                    drop_reg   <= (in_ch.new_rate_id < in_ch.old_rate_id) ||
                                  in_ch.action == ACT_DROP || in_ch.action == ACT_DEGRADED;
                end
                OP_LOOKUP: phy_reg  <= phy_rate(new_id_reg);
                OP_MUL:    prod_reg <= BR_W'(phy_reg) * BR_W'(headroom_reg);
                OP_CLAMP:  br_reg   <= clamped;
                default:   ;
            endcase
        end
        if (emit) begin
            out_cmd_reg <= emit_cmd;
            out_br_reg  <= (emit_cmd == CMD_ENCODER) ? br_reg : '0;
            out_id_reg  <= (emit_cmd == CMD_DRIVER) ? new_id_reg : '0;
            out_fin_reg <= emit_fin;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.command   = out_cmd_reg;
    assign out_ch.enc_kbps  = out_br_reg;
    assign out_ch.rate_id   = out_id_reg;
    assign out_ch.final_res = out_fin_reg;
endmodule

>>> verif/lrtb_cmd_checker.sv
// Command checker for link_rate_to_encoder_bitrate: mirrors register writes, predicts the
// encoder and driver commands of each event transfer and compares them in order.
// Depends on lrtb_pkg, lrtb_in_if and lrtb_out_if.
module lrtb_cmd_checker
    import lrtb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [BR_W-1:0]   cfg_data,
    lrtb_in_if                in_ch,
    lrtb_out_if               out_ch,
    output int                fail_count,
    output int                cmds_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic            command;
        logic [BR_W-1:0] enc_kbps;
        logic [ID_W-1:0] rate_id;
        logic            final_res;
    } rate_cmd_t;

    rate_cmd_t       expected_cmds[$];
    rate_cmd_t       seen_cmd;
    rate_cmd_t       want_cmd;
    logic [HR_W-1:0] headroom;
    logic [BR_W-1:0] cap_kbps;
    logic            sync_mode;
    logic [BR_W-1:0] current_kbps;
    int              mismatches = 0;
    int              outstanding = 0;

    assign fail_count   = mismatches;
    assign cmds_pending = outstanding;

    // PHY rate of a descriptor rate ID in 100 kbps units
    function automatic int phy_100k(input logic [ID_W-1:0] id);
        int base;
        int d;
        int mcs;
        int nss;
        int lgi;
        int sgi;
        int r;
        base = int'(id[6:0]);
        mcs  = 0;
        nss  = 1;
        lgi  = 0;
        sgi  = 0;
        r    = 0;
        if (base <= int'(LEGACY_LAST))
        begin
            case (base)
                0:  r = 10;
                1:  r = 20;
                2:  r = 55;
                3:  r = 110;
                4:  r = 60;
                5:  r = 90;
                6:  r = 120;
                7:  r = 180;
                8:  r = 240;
                9:  r = 360;
                10: r = 480;
                11: r = 540;
                default: r = 0;
            endcase
            return r;
        end
        if (base <= int'(HT_LAST))
        begin
            d   = base - int'(HT_FIRST);
            mcs = d % 8;
            nss = d / 8 + 1;
        end
        else if (base <= int'(VHT_LAST))
        begin
            d   = base - int'(VHT_FIRST);
            mcs = d % 10;
            nss = d / 10 + 1;
        end
        else
        begin
            return int'(UNKNOWN_RATE);
        end
        case (mcs)
            0: begin lgi = 65;  sgi = 72;  end
            1: begin lgi = 130; sgi = 144; end
            2: begin lgi = 195; sgi = 217; end
            3: begin lgi = 260; sgi = 289; end
            4: begin lgi = 390; sgi = 433; end
            5: begin lgi = 520; sgi = 578; end
            6: begin lgi = 585; sgi = 650; end
            7: begin lgi = 650; sgi = 722; end
            8: begin lgi = 780; sgi = 867; end
            9: begin lgi = 867; sgi = 963; end
            default: begin lgi = 0; sgi = 0; end
        endcase
        return (id[7] ? sgi : lgi) * nss;
    endfunction

    function automatic logic [BR_W-1:0] encoder_kbps(input logic [ID_W-1:0] id);
        int k;
        k = phy_100k(id) * int'(headroom);
        if (cap_kbps != '0 && k > int'(cap_kbps))
            k = int'(cap_kbps);
        if (k < int'(FLOOR_KBPS))
            k = int'(FLOOR_KBPS);
        return BR_W'(k);
    endfunction

    task automatic predict_commands(input logic [ACT_W-1:0] act,
                                    input logic [ID_W-1:0] old_id,
                                    input logic [ID_W-1:0] new_id);
        logic [BR_W-1:0] br;
        rate_cmd_t       enc;
        rate_cmd_t       drv;
        // drop unknown kinds without touching state
        if (act > ACT_RECOVERED)
            return;
        br = encoder_kbps(new_id);
        if (br == current_kbps)
            return;
        current_kbps = br;
        enc = '{CMD_ENCODER, br, '0, 1'b1};
        drv = '{CMD_DRIVER, '0, new_id, 1'b1};
        if (!sync_mode)
        begin
            expected_cmds.push_back(enc);
        end
        else if (new_id < old_id || act == ACT_DROP || act == ACT_DEGRADED)
        begin
            // lower the encoder before the driver
            enc.final_res = 1'b0;
            expected_cmds.push_back(enc);
            expected_cmds.push_back(drv);
        end
        else
        begin
            // raise the driver before the encoder
            drv.final_res = 1'b0;
            expected_cmds.push_back(drv);
            expected_cmds.push_back(enc);
        end
    endtask

    task automatic compare_field(input string field, input int want, input int seen);
        if (want != seen)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            headroom     = HEADROOM_RESET;
            cap_kbps     = CAP_RESET;
            sync_mode    = 1'b0;
            current_kbps = START_RESET;
            expected_cmds.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                seen_cmd = '{out_ch.command, out_ch.enc_kbps, out_ch.rate_id,
                             out_ch.final_res};
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: unexpected command transfer: command %0d",
                             $time, seen_cmd.command,
                             " enc_kbps %0d rate id %0d final %0d",
                             seen_cmd.enc_kbps, seen_cmd.rate_id, seen_cmd.final_res);
                    mismatches++;
                end
                else
                begin
                    want_cmd = expected_cmds.pop_front();
                    compare_field("command", int'(want_cmd.command),
                                  int'(seen_cmd.command));
                    compare_field("enc_kbps", int'(want_cmd.enc_kbps),
                                  int'(seen_cmd.enc_kbps));
                    compare_field("rate_id", int'(want_cmd.rate_id),
                                  int'(seen_cmd.rate_id));
                    compare_field("final_res", int'(want_cmd.final_res),
                                  int'(seen_cmd.final_res));
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_commands(in_ch.action, in_ch.old_rate_id, in_ch.new_rate_id);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HEADROOM: headroom  = cfg_data[HR_W-1:0];
                    REG_CAP:      cap_kbps  = cfg_data;
                    REG_SYNC:     sync_mode = cfg_data[0];
                    REG_START:    current_kbps = cfg_data;
                    default: ;
                endcase
            end
        end
        outstanding = expected_cmds.size();
    end

endmodule

>>> verif/link_rate_to_encoder_bitrate_tb.sv
// Top of the link_rate_to_encoder_bitrate testbench: clock, reset, register writes,
// event stimulus and receiver back-pressure; the verdict comes from lrtb_cmd_checker.
// Depends on lrtb_pkg, lrtb_in_if, lrtb_out_if, lrtb_cmd_checker and the block.
module link_rate_to_encoder_bitrate_tb
    import lrtb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 300;

    localparam logic [ACT_W-1:0] ACT_OTHER = ACT_RECOVERED + 3'd1;
    localparam logic [ACT_W-1:0] ACT_TOP   = '1;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [BR_W-1:0]   cfg_data;
    int                fail_count;
    int                cmds_pending;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                long_hold;
    int                cycle_cnt;
    logic [ID_W-1:0]   last_new_id;

    lrtb_in_if  in_ch();
    lrtb_out_if out_ch();

    link_rate_to_encoder_bitrate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    lrtb_cmd_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .fail_count   (fail_count),
        .cmds_pending (cmds_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    // receiver: random back-pressure, or a long hold when one is requested
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                long_hold--;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic send_event(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] old_id,
                              input logic [ID_W-1:0] new_id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.old_rate_id <= old_id;
        in_ch.new_rate_id <= new_id;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold the sender until every expected command is out and the block is idle
    task automatic settle();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (cmds_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [BR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [HR_W-1:0] hr, input logic [BR_W-1:0] cap,
                                input logic sync, input logic [BR_W-1:0] start);
        settle();
        write_reg(REG_HEADROOM, BR_W'(hr));
        write_reg(REG_CAP, cap);
        write_reg(REG_SYNC, BR_W'(sync));
        write_reg(REG_START, start);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // mostly known rate IDs and rate-change kinds; repeats of the last ID give no-change events
    task automatic random_events(input int count);
        int              sent;
        int              pick;
        logic [ACT_W-1:0] act;
        logic [ID_W-1:0]  old_id;
        logic [ID_W-1:0]  new_id;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 12)
                act = ACT_W'($urandom_range(int'(ACT_TOP), int'(ACT_OTHER)));
            else
                act = ACT_W'($urandom_range(int'(ACT_RECOVERED), int'(ACT_DROP)));
            old_id = ($urandom_range(1) == 0) ? last_new_id : ID_W'($urandom);
            pick = $urandom_range(9);
            if (pick < 2)
                new_id = last_new_id;
            else if (pick < 8)
                new_id = {1'($urandom), 7'($urandom_range(int'(VHT_LAST)))};
            else
                new_id = ID_W'($urandom);
            send_event(act, old_id, new_id);
            last_new_id = new_id;
            sent++;
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_HEADROOM;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_DROP;
        in_ch.old_rate_id = '0;
        in_ch.new_rate_id = '0;
        send_idle_pct     = 25;
        recv_idle_pct     = 58;
        long_hold         = 0;
        last_new_id       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: table edges, guard bit, unknown IDs, ignored kinds, no-change
        send_event(ACT_DROP, 8'h0b, 8'h00);
        send_event(ACT_RISE, 8'h00, 8'h0b);
        send_event(ACT_RISE, 8'h0b, 8'h0b);
        send_event(ACT_OTHER, 8'h0b, 8'h2b);
        send_event(ACT_TOP, 8'hff, 8'h00);
        send_event(ACT_RECOVERED, 8'h00, 8'h0c);
        send_event(ACT_RISE, 8'h0c, 8'h8c);
        send_event(ACT_RISE, 8'h8c, 8'h2b);
        send_event(ACT_DEGRADED, 8'h2b, 8'h2c);
        send_event(ACT_RISE, 8'h2c, 8'hd3);
        send_event(ACT_DROP, 8'hd3, 8'h54);
        send_event(ACT_RISE, 8'h54, 8'h7f);
        send_event(ACT_RISE, 8'h7f, 8'hff);
        send_event(ACT_DROP, 8'hff, 8'h80);

        // sync mode: both command orders; start value equal to the first result
        program_regs(7'd100, 19'd0, 1'b1, 19'd1000);
        send_event(ACT_DROP, 8'h80, 8'h00);
        send_event(ACT_RISE, 8'h00, 8'hd3);
        send_event(ACT_RISE, 8'hd3, 8'h53);
        send_event(ACT_DEGRADED, 8'h00, 8'h2b);
        send_event(ACT_RECOVERED, 8'h2b, 8'hab);
        send_event(ACT_DROP, 8'h00, 8'h0b);

        program_regs(7'h7f, 19'h7ffff, 1'b1, 19'd0);
        send_event(ACT_RISE, 8'h00, 8'hd3);
        send_event(ACT_DEGRADED, 8'hd3, 8'hd3);
        send_event(ACT_RECOVERED, 8'hd3, 8'h01);

        program_regs(7'd0, 19'd25000, 1'b0, 19'd0);
        random_events(60);

        program_regs(7'd100, 19'd385200, 1'b1, 19'd385200);
        long_hold = LONG_HOLD;
        random_events(400);

        send_idle_pct = 58;
        recv_idle_pct = 25;
        program_regs(7'h7f, 19'd0, 1'b1, 19'd12345);
        random_events(200);
        settle();
        random_events(200);

        program_regs(7'($urandom_range(100, 1)), 19'($urandom_range(385200)),
                     1'($urandom), 19'($urandom_range(385200)));
        random_events(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs(7'd50, 19'd10000, 1'b0, 19'd500);
        random_events(300);

        program_regs(7'h7f, 19'h7ffff, 1'b1, 19'h7ffff);
        random_events(400);

        settle();
        if (fail_count == 0 && cmds_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/lrtb_pkg.sv
rtl/lrtb_in_if.sv
rtl/lrtb_out_if.sv
rtl/lrtb_sequencer.sv
rtl/lrtb_datapath.sv
rtl/link_rate_to_encoder_bitrate.sv
verif/lrtb_cmd_checker.sv
verif/link_rate_to_encoder_bitrate_tb.sv
